// ----- rtl/core/thin_multipole_kick_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the multipole kick core.
// ----------------------------------------------------------------------------
`ifndef THIN_MULTIPOLE_KICK_DEFINES_SVH
`define THIN_MULTIPOLE_KICK_DEFINES_SVH
`ifndef SYNTH
`define TMK_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define TMK_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define TMK_ASSERT_IMP(label, clk, rst_n, a, c)
`define TMK_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ----- rtl/core/tmk_pkg.sv -----
// ----------------------------------------------------------------------------
// tmk_pkg
// Shared constants, types and saturating Q8.24 arithmetic for the kick core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tmk_pkg;

  localparam int MaxOrder  = 8;
  localparam int FracBits  = 24;
  localparam int ValW      = 32;
  localparam int OrdW      = 4;
  localparam int CfgIdxW   = 3;

  typedef logic signed [ValW-1:0] val_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ORDER  = 3'd0,
    REG_STRENGTH = 3'd1,
    REG_COS    = 3'd2,
    REG_SIN    = 3'd3,
    REG_OFS_X  = 3'd4,
    REG_OFS_Y  = 3'd5
  } cfg_idx_t;

  // Value plus a sticky overflow flag.
  typedef struct packed {
    val_t re;
    val_t im;
    logic ovf;
  } cplx_t;

  localparam val_t VMAX = {1'b0, {(ValW-1){1'b1}}};
  localparam val_t VMIN = {1'b1, {(ValW-1){1'b0}}};

  // Saturating add, bit 0 of the result is the overflow flag.
  function automatic logic [ValW:0] sat_add(input val_t a, input val_t b);
    logic signed [ValW:0] s;
    begin
      s = {a[ValW-1], a} + {b[ValW-1], b};
      if (s > $signed({2'b00, VMAX[ValW-2:0]})) sat_add = {VMAX, 1'b1};
      else if (s < $signed({2'b11, VMIN[ValW-2:0]})) sat_add = {VMIN, 1'b1};
      else sat_add = {s[ValW-1:0], 1'b0};
    end
  endfunction

  function automatic logic [ValW:0] sat_sub(input val_t a, input val_t b);
    logic signed [ValW:0] s;
    begin
      s = {a[ValW-1], a} - {b[ValW-1], b};
      if (s > $signed({2'b00, VMAX[ValW-2:0]})) sat_sub = {VMAX, 1'b1};
      else if (s < $signed({2'b11, VMIN[ValW-2:0]})) sat_sub = {VMIN, 1'b1};
      else sat_sub = {s[ValW-1:0], 1'b0};
    end
  endfunction

  // Round an exact product to Q8.24, half away from zero, and saturate.
  function automatic logic [ValW:0] round_prod(input logic signed [2*ValW-1:0] p);
    logic        neg;
    logic [2*ValW-1:0] m;
    logic [2*ValW-1:0] q;
    begin
      neg = p[2*ValW-1];
      m   = neg ? (~p + 1'b1) : p;
      q   = (m + (64'd1 << (FracBits-1))) >> FracBits;
      if (!neg && q > {32'd0, VMAX}) round_prod = {VMAX, 1'b1};
      else if (neg && q > {32'd0, VMAX} + 64'd1) round_prod = {VMIN, 1'b1};
      else if (neg) round_prod = {val_t'(~q[ValW-1:0] + 1'b1), 1'b0};
      else round_prod = {q[ValW-1:0], 1'b0};
    end
  endfunction

endpackage

// ----- rtl/core/thin_multipole_kick.sv -----
// ----------------------------------------------------------------------------
// thin_multipole_kick
// Thin-lens normal multipole kick on one particle, Q8.24 fixed point.
// ----------------------------------------------------------------------------
// Usage: drive pos/mom inputs with in_start; a beat is taken when in_start is
// high and in_busy is low. in_busy is always low: one particle per cycle.
// Each result appears on out_new_mom_x, out_new_mom_y and out_overflow for one
// cycle with out_valid high, once its input beat has passed the front stage, the
// reciprocal divider and the alignment, scaling and output registers. The
// divider (49 stages) runs in parallel with the tilt and the power chain
// (MaxOrder complex multiplies of two stages each), which is padded to meet
// it; the strength product is registered from config. Configuration writes go
// through cfg_valid/cfg_ready (always ready) with cfg_index and cfg_data;
// they must be written by the user only while the pipe is empty; the block
// does not enforce this. Reset clears the valid pipe and restores register
// defaults (tilt_cos = 1.0). The receiver cannot stall; no backpressure exists.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "thin_multipole_kick_defines.svh"
module thin_multipole_kick import tmk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_start,
  output logic                 in_busy,
  input  logic signed [31:0]   in_pos_x,
  input  logic signed [31:0]   in_pos_y,
  input  logic signed [31:0]   in_mom_x,
  input  logic signed [31:0]   in_mom_y,
  input  logic signed [31:0]   in_mom_dev,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [31:0]          cfg_data,
  output logic                 out_valid,
  output logic signed [31:0]   out_new_mom_x,
  output logic signed [31:0]   out_new_mom_y,
  output logic                 out_overflow
);

  localparam int PowLat = 2 + 2*MaxOrder;  // tilt stage (2) plus power chain
  localparam int DivLat = 2*FracBits + 1;
  localparam int Lat    = DivLat + 1;      // front stage + divider
  localparam int PadLen = Lat - PowLat - 1;// align power chain to divider
  localparam int Total  = Lat + 4;         // kick stages after alignment

  assign in_busy   = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  logic [OrdW-1:0] ord_r;
  val_t str_r, cos_r, sin_r, ox_r, oy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ord_r <= '0; str_r <= '0; cos_r <= val_t'(32'sd16777216);
      sin_r <= '0; ox_r <= '0; oy_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        REG_ORDER:    ord_r <= cfg_data[OrdW-1:0];
        REG_STRENGTH: str_r <= cfg_data;
        REG_COS:      cos_r <= cfg_data;
        REG_SIN:      sin_r <= cfg_data;
        REG_OFS_X:    ox_r  <= cfg_data;
        REG_OFS_Y:    oy_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [OrdW-1:0] ord_eff;
  assign ord_eff = (ord_r > OrdW'(MaxOrder)) ? OrdW'(MaxOrder) : ord_r;

  // Valid shift line.
  logic [Total-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[Total-2:0], in_start && !in_busy};
  end

  // Front stage: offsets and denominator.
  logic [ValW:0] dx_s, dy_s, d_s;
  cplx_t dxy_r;
  val_t  d_r;
  always_comb begin
    dx_s = sat_sub(in_pos_x, ox_r);
    dy_s = sat_sub(in_pos_y, oy_r);
    d_s  = sat_add(val_t'(32'sd16777216), in_mom_dev);
  end
  // A saturated denominator travels with the offset flags.
  always_ff @(posedge clk) begin
    dxy_r <= '{re: dx_s[ValW:1], im: dy_s[ValW:1], ovf: dx_s[0] | dy_s[0] | d_s[0]};
    d_r   <= d_s[ValW:1];
  end

  // Tilt: xl + i*zl = (dx + i*dy) * (c - i*s).
  cplx_t z;
  tmk_cmul u_tilt (.clk(clk), .a(dxy_r), .b(cplx_t'{re: cos_r, im: sin_r, ovf: 1'b0}),
                   .conj_b(1'b1), .y(z));

  // Power chain: each stage multiplies by z when the order asks for it.
  cplx_t pw [MaxOrder+1];
  cplx_t zd [MaxOrder+1];
  assign pw[0] = z;
  assign zd[0] = z;
  for (genvar k = 0; k < MaxOrder; k++) begin : g_pow
    cplx_t prod, hold_p, hold_p2, hold_z, hold_z2;
    tmk_cmul u_m (.clk(clk), .a(pw[k]), .b(zd[k]), .conj_b(1'b0), .y(prod));
    always_ff @(posedge clk) begin
      hold_p <= pw[k]; hold_p2 <= hold_p;
      hold_z <= zd[k]; hold_z2 <= hold_z;
    end
    assign pw[k+1] = (ord_eff > OrdW'(k)) ? prod : hold_p2;
    assign zd[k+1] = hold_z2;
  end

  // Delay lines for side data to meet the divider output.
  cplx_t pw_d [PadLen+1];
  assign pw_d[0] = pw[MaxOrder];
  for (genvar j = 0; j < PadLen; j++) begin : g_pad
    always_ff @(posedge clk) pw_d[j+1] <= pw_d[j];
  end

  logic signed [31:0] px_d [Lat+1];
  logic signed [31:0] py_d [Lat+1];
  logic               dn_d [Lat+1];
  assign px_d[0] = in_mom_x;
  assign py_d[0] = in_mom_y;
  assign dn_d[0] = d_s[ValW] | (d_s[ValW:1] == '0);
  for (genvar j = 0; j < Lat; j++) begin : g_side
    always_ff @(posedge clk) begin
      px_d[j+1] <= px_d[j]; py_d[j+1] <= py_d[j]; dn_d[j+1] <= dn_d[j];
    end
  end

  // Reciprocal of the denominator.
  logic [2*FracBits:0] rq;
  tmk_recip u_recip (.clk(clk), .d(d_r), .q(rq));
  logic [ValW:0] r_s;
  always_comb begin
    if (rq > {17'd0, VMAX}) r_s = {VMAX, 1'b1};
    else r_s = {rq[ValW-1:0], 1'b0};
  end

  // Strength times tilt (lc + i*ls), registered from config in two steps.
  logic signed [2*ValW-1:0] lc_p_r, ls_p_r;
  logic [ValW:0] lc_s, ls_s;
  always_ff @(posedge clk) begin
    lc_p_r <= str_r * cos_r;
    ls_p_r <= str_r * sin_r;
    lc_s   <= round_prod(lc_p_r);
    ls_s   <= round_prod(ls_p_r);
  end

  // Kick: (lc + i*ls) * conj(cr + i*ci) -> (ka, kb).
  cplx_t kab;
  cplx_t pw_a;
  assign pw_a = '{re: pw_d[PadLen].re, im: pw_d[PadLen].im,
                  ovf: pw_d[PadLen].ovf | lc_s[0] | ls_s[0]};
  tmk_cmul u_kick (.clk(clk),
                   .a(cplx_t'{re: lc_s[ValW:1], im: ls_s[ValW:1], ovf: 1'b0}),
                   .b(pw_a), .conj_b(1'b1), .y(kab));

  // Side data aligned with the kick multiplier.
  val_t r_a, r_b;
  logic rov_a, rov_b;
  logic signed [31:0] px_a, px_b, py_a, py_b;
  logic dn_a, dn_b;
  always_ff @(posedge clk) begin
    r_a <= r_s[ValW:1]; rov_a <= r_s[0];
    px_a <= px_d[Lat]; py_a <= py_d[Lat]; dn_a <= dn_d[Lat];
    r_b <= r_a; rov_b <= rov_a; px_b <= px_a; py_b <= py_a; dn_b <= dn_a;
  end

  // Scale by reciprocal.
  logic signed [2*ValW-1:0] sx_r, sy_r;
  logic sovf_r, sdn_r, srov_r;
  logic signed [31:0] spx_r, spy_r;
  always_ff @(posedge clk) begin
    sx_r <= r_b * kab.re;
    sy_r <= r_b * kab.im;
    sovf_r <= kab.ovf; srov_r <= rov_b; sdn_r <= dn_b;
    spx_r <= px_b; spy_r <= py_b;
  end

  logic [ValW:0] qx, qy, ax, ay;
  logic signed [31:0] nx_nxt, ny_nxt;
  logic ov_nxt;
  always_comb begin
    qx = round_prod(sx_r);
    qy = round_prod(sy_r);
    ax = sat_add(spx_r, qx[ValW:1]);
    ay = sat_add(spy_r, qy[ValW:1]);
    if (sdn_r) begin
      nx_nxt = spx_r; ny_nxt = spy_r; ov_nxt = 1'b1;
    end else begin
      nx_nxt = ax[ValW:1]; ny_nxt = ay[ValW:1];
      ov_nxt = sovf_r | srov_r | qx[0] | qy[0] | ax[0] | ay[0];
    end
  end

  always_ff @(posedge clk) begin
    out_new_mom_x <= nx_nxt;
    out_new_mom_y <= ny_nxt;
    out_overflow  <= ov_nxt;
  end
  assign out_valid = vld_r[Total-1];

  `TMK_ASSERT_IMP(a_never_busy, clk, rst_n, 1'b1, !in_busy)
  `TMK_ASSERT_NEXT(a_flow, clk, rst_n, vld_r[Total-2], out_valid)
  `TMK_ASSERT_NEXT(a_nodrop, clk, rst_n, !vld_r[Total-2], !out_valid)

endmodule

// ----- rtl/core/tmk_cmul.sv -----
// ----------------------------------------------------------------------------
// tmk_cmul
// Two-stage complex multiply: four products registered, then combined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tmk_cmul import tmk_pkg::*; (
  input  logic  clk,
  input  cplx_t a,
  input  cplx_t b,
  input  logic  conj_b,
  output cplx_t y
);

  // Stage one: exact products registered, then rounded to Q8.24 after the register.
  logic signed [2*ValW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic ovf_r, conj_r;
  always_ff @(posedge clk) begin
    p_rr_r <= a.re * b.re;
    p_ii_r <= a.im * b.im;
    p_ri_r <= a.re * b.im;
    p_ir_r <= a.im * b.re;
    ovf_r  <= a.ovf | b.ovf;
    conj_r <= conj_b;
  end

  logic [ValW:0] q_rr, q_ii, q_ri, q_ir, s_re, s_im;
  cplx_t y_nxt;
  always_comb begin
    q_rr = round_prod(p_rr_r);
    q_ii = round_prod(p_ii_r);
    q_ri = round_prod(p_ri_r);
    q_ir = round_prod(p_ir_r);
    // Normal: (ar*br - ai*bi, ar*bi + ai*br). Conjugate of b: signs flip on bi terms.
    if (conj_r) begin
      s_re = sat_add(q_rr[ValW:1], q_ii[ValW:1]);
      s_im = sat_sub(q_ir[ValW:1], q_ri[ValW:1]);
    end else begin
      s_re = sat_sub(q_rr[ValW:1], q_ii[ValW:1]);
      s_im = sat_add(q_ri[ValW:1], q_ir[ValW:1]);
    end
    y_nxt.re  = s_re[ValW:1];
    y_nxt.im  = s_im[ValW:1];
    y_nxt.ovf = ovf_r | q_rr[0] | q_ii[0] | q_ri[0] | q_ir[0] | s_re[0] | s_im[0];
  end

  // Stage two register.
  always_ff @(posedge clk) begin
    y <= y_nxt;
  end

endmodule

// ----- rtl/core/tmk_recip.sv -----
// ----------------------------------------------------------------------------
// tmk_recip
// Pipelined restoring divider for round(2^48 / d), one quotient bit a stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tmk_recip import tmk_pkg::*; (
  input  logic       clk,
  input  val_t       d,
  output logic [2*FracBits:0] q
);

  localparam int QW = 2*FracBits + 1;   // quotient bits
  localparam int RW = ValW + 1;         // remainder bits

  // Dividend is 2^48 + floor(d/2); remainder chain over QW stages.
  logic [RW-1:0]  rem_r [QW+1];
  logic [QW-1:0]  quo_r [QW+1];
  logic [QW-1:0]  num_r [QW+1];
  val_t           den_r [QW+1];

  always_comb begin
    rem_r[0] = '0;
    quo_r[0] = '0;
    num_r[0] = (QW'(1) << (2*FracBits)) + QW'(d >>> 1);
    den_r[0] = d;
  end

  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic [RW:0] trial;
    logic [RW:0] shifted;
    always_comb begin
      shifted = {rem_r[g], num_r[g][QW-1-g]};
      trial   = shifted - {2'b00, den_r[g]};
    end
    always_ff @(posedge clk) begin
      if (!trial[RW]) begin
        rem_r[g+1] <= trial[RW-1:0];
        quo_r[g+1] <= {quo_r[g][QW-2:0], 1'b1};
      end else begin
        rem_r[g+1] <= shifted[RW-1:0];
        quo_r[g+1] <= {quo_r[g][QW-2:0], 1'b0};
      end
      num_r[g+1] <= num_r[g];
      den_r[g+1] <= den_r[g];
    end
  end

  assign q = quo_r[QW];

endmodule
